>>> rtl/core/sliding_window_latency_jitter_stats_top_defines.svh
// Assertion macros shared by the checker of the latency and jitter statistics block.
// Depends on nothing. The using module must have aclk and aresetn in scope.
`ifndef SLIDING_WINDOW_LATENCY_JITTER_STATS_TOP_DEFINES_SVH
`define SLIDING_WINDOW_LATENCY_JITTER_STATS_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWLJS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWLJS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/swljs_pkg.sv
// Shared types and constants of the latency and jitter statistics block.
// Depends on nothing.
package swljs_pkg;

    localparam int DEFAULT_WINDOW     = 32;
    localparam int DEFAULT_VALUE_BITS = 24;

    localparam int STAMP_W = 64;
    localparam int NOW_W   = 24;
    localparam int STAT_W  = 28;
    localparam int FILL_W  = 6;
    localparam int TOTAL_W = 32;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } swljs_op_t;

    typedef struct packed {
        logic      start;
        swljs_op_t op;
    } swljs_cmd_t;

endpackage

>>> rtl/core/sliding_window_latency_jitter_stats_top.sv
// Sliding window latency and arrival gap statistics, top level and sequencer.
// The time that one item takes is set by the shared
// serial unit: per window at most two divides of DW steps, one square root of DW/2 steps and four
// multiplies that stop when the multiplier runs out of ones, DW = 2*VALUE_BITS+2*clog2(WINDOW+1)+8.
// Throughput: one item at a time; the next item is taken once the result is in the output register.
// Reset: synchronous active low aresetn clears the windows, counters and handshake state.
module sliding_window_latency_jitter_stats_top
    import swljs_pkg::*;
#(
    parameter int WINDOW     = DEFAULT_WINDOW,
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [STAMP_W-1:0] s_sent_stamp,
    input  logic [STAMP_W-1:0] s_arrival_stamp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [NOW_W-1:0]   m_latency_now,
    output logic [NOW_W-1:0]   m_gap_now,
    output logic [STAT_W-1:0]  m_latency_mean,
    output logic [STAT_W-1:0]  m_latency_spread,
    output logic [STAT_W-1:0]  m_gap_mean,
    output logic [STAT_W-1:0]  m_gap_spread,
    output logic [FILL_W-1:0]  m_latency_fill,
    output logic [FILL_W-1:0]  m_gap_fill,
    output logic [TOTAL_W-1:0] m_message_total
);

    // Widths of the window bookkeeping. DW holds n*sum_sq and sum^2 shifted left by eight,
    // which is the widest value the shared unit ever sees.
    localparam int V        = VALUE_BITS;
    localparam int HB       = $clog2(WINDOW);
    localparam int CNT_BITS = $clog2(WINDOW + 1);
    localparam int SUM_BITS = V + CNT_BITS;
    localparam int SQ_BITS  = 2 * V + CNT_BITS;
    localparam int DW       = 2 * V + 2 * CNT_BITS + 8;

    // The sequencer walks the latency window first and then the gap window.
    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000_0000_0000_0001,
        ST_READ   = 16'b0000_0000_0000_0010,
        ST_OLD    = 16'b0000_0000_0000_0100,
        ST_OLD_W  = 16'b0000_0000_0000_1000,
        ST_NEW    = 16'b0000_0000_0001_0000,
        ST_NEW_W  = 16'b0000_0000_0010_0000,
        ST_MEAN   = 16'b0000_0000_0100_0000,
        ST_MEAN_W = 16'b0000_0000_1000_0000,
        ST_NSQ    = 16'b0000_0001_0000_0000,
        ST_NSQ_W  = 16'b0000_0010_0000_0000,
        ST_S2     = 16'b0000_0100_0000_0000,
        ST_S2_W   = 16'b0000_1000_0000_0000,
        ST_ROOT   = 16'b0001_0000_0000_0000,
        ST_ROOT_W = 16'b0010_0000_0000_0000,
        ST_SDIV_W = 16'b0100_0000_0000_0000,
        ST_DONE   = 16'b1000_0000_0000_0000
    } state_t;

    // Difference of two stamps, zero when they run backwards, saturated to the value width.
    function automatic logic [V-1:0] clamp_diff(input logic [STAMP_W-1:0] later,
                                                input logic [STAMP_W-1:0] earlier);
        logic [STAMP_W-1:0] d;
        d = (later >= earlier) ? (later - earlier) : '0;
        return ((d >> V) != '0) ? '1 : d[V-1:0];
    endfunction

    function automatic logic [STAT_W-1:0] sat_stat(input logic [DW-1:0] v);
        return ((v >> STAT_W) != '0) ? '1 : v[STAT_W-1:0];
    endfunction

    function automatic logic [NOW_W-1:0] sat_now(input logic [V-1:0] v);
        logic [STAMP_W-1:0] w;
        w = STAMP_W'(v);
        return ((w >> NOW_W) != '0) ? '1 : w[NOW_W-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] sat_fill(input logic [CNT_BITS-1:0] c);
        logic [15:0] w;
        w = 16'(c);
        return ((w >> FILL_W) != '0) ? '1 : w[FILL_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic                 win_sel_reg, win_sel_next;
    logic [V-1:0]         lat_val_reg, lat_val_next;
    logic [V-1:0]         gap_val_reg, gap_val_next;
    logic                 push_gap_reg, push_gap_next;
    logic [STAMP_W-1:0]   prev_reg, prev_next;
    logic                 have_prev_reg, have_prev_next;
    logic [TOTAL_W-1:0]   msg_reg, msg_next;
    logic [HB-1:0]        head_reg [2];
    logic [HB-1:0]        head_next [2];
    logic [CNT_BITS-1:0]  count_reg [2];
    logic [CNT_BITS-1:0]  count_next [2];
    logic [SUM_BITS-1:0]  sum_reg [2];
    logic [SUM_BITS-1:0]  sum_next [2];
    logic [SQ_BITS-1:0]   sq_reg [2];
    logic [SQ_BITS-1:0]   sq_next [2];
    logic [STAT_W-1:0]    mean_reg [2];
    logic [STAT_W-1:0]    mean_next [2];
    logic [STAT_W-1:0]    spread_reg [2];
    logic [STAT_W-1:0]    spread_next [2];
    logic [DW-1:0]        oldsq_reg, oldsq_next;
    logic [DW-1:0]        nsq_reg, nsq_next;
    logic [DW-1:0]        s2_reg, s2_next;
    logic                 m_valid_reg, m_valid_next;

    logic [NOW_W-1:0]     o_lat_now_reg, o_gap_now_reg;
    logic [STAT_W-1:0]    o_lmean_reg, o_lspread_reg, o_gmean_reg, o_gspread_reg;
    logic [FILL_W-1:0]    o_lfill_reg, o_gfill_reg;
    logic [TOTAL_W-1:0]   o_total_reg;
    logic                 load_out;

    swljs_cmd_t           cmd;
    logic [DW-1:0]        unit_a, unit_b, unit_res;
    logic                 unit_done;

    logic                 ram_we;
    logic [HB:0]          ram_addr;
    logic [V-1:0]         ram_rdata;

    logic [V-1:0]         cur_val;
    logic                 cur_full;
    logic [V-1:0]         old_val;
    logic [DW:0]          var_diff;

    // The ring of each window lives in one half of a shared RAM. The read address
    // follows the head of the selected window, so the oldest entry is read out in the next cycle.
    assign ram_addr = {win_sel_reg, head_reg[win_sel_reg]};
    assign cur_val  = win_sel_reg ? gap_val_reg : lat_val_reg;
    assign cur_full = (count_reg[win_sel_reg] == CNT_BITS'(WINDOW));
    assign old_val  = cur_full ? ram_rdata : '0;
    assign var_diff = {1'b0, nsq_reg} - {1'b0, s2_reg};

    swljs_ram #(
        .WIDTH (V),
        .DEPTH (2 ** (HB + 1))
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (cur_val),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    swljs_serial_unit #(
        .DW (DW)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (unit_a),
        .opb     (unit_b),
        .result  (unit_res),
        .done    (unit_done)
    );

    always_comb begin
        state_next     = state_reg;
        win_sel_next   = win_sel_reg;
        lat_val_next   = lat_val_reg;
        gap_val_next   = gap_val_reg;
        push_gap_next  = push_gap_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        msg_next       = msg_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        mean_next      = mean_reg;
        spread_next    = spread_reg;
        oldsq_next     = oldsq_reg;
        nsq_next       = nsq_reg;
        s2_next        = s2_reg;
        cmd.start      = 1'b0;
        cmd.op         = OP_MUL;
        unit_a         = '0;
        unit_b         = '0;
        ram_we         = 1'b0;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    lat_val_next   = clamp_diff(s_arrival_stamp, s_sent_stamp);
                    gap_val_next   = have_prev_reg ? clamp_diff(s_arrival_stamp, prev_reg) : '0;
                    push_gap_next  = have_prev_reg;
                    prev_next      = s_arrival_stamp;
                    have_prev_next = 1'b1;
                    msg_next       = msg_reg + TOTAL_W'(1);
                    win_sel_next   = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ: begin
                // The very first item has no gap; its gap window is only reported.
                state_next = (win_sel_reg && !push_gap_reg) ? ST_MEAN : ST_OLD;
            end
            ST_OLD: begin
                if (cur_full) begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    unit_a     = DW'(ram_rdata);
                    unit_b     = DW'(ram_rdata);
                    state_next = ST_OLD_W;
                end else begin
                    oldsq_next = '0;
                    state_next = ST_NEW;
                end
            end
            ST_OLD_W: begin
                if (unit_done) begin
                    oldsq_next = unit_res;
                    state_next = ST_NEW;
                end
            end
            ST_NEW: begin
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                unit_a     = DW'(cur_val);
                unit_b     = DW'(cur_val);
                state_next = ST_NEW_W;
            end
            ST_NEW_W: begin
                if (unit_done) begin
                    sum_next[win_sel_reg] = sum_reg[win_sel_reg] - SUM_BITS'(old_val)
                                          + SUM_BITS'(cur_val);
                    sq_next[win_sel_reg]  = sq_reg[win_sel_reg] - SQ_BITS'(oldsq_reg)
                                          + SQ_BITS'(unit_res);
                    ram_we = 1'b1;
                    head_next[win_sel_reg] = (head_reg[win_sel_reg] == HB'(WINDOW - 1)) ? '0 :
                                             head_reg[win_sel_reg] + HB'(1);
                    if (!cur_full) begin
                        count_next[win_sel_reg] = count_reg[win_sel_reg] + CNT_BITS'(1);
                    end
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (count_reg[win_sel_reg] == '0) begin
                    mean_next[win_sel_reg]   = '0;
                    spread_next[win_sel_reg] = '0;
                    win_sel_next = 1'b1;
                    state_next   = win_sel_reg ? ST_DONE : ST_READ;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    unit_a     = DW'(sum_reg[win_sel_reg]) << 4;
                    unit_b     = DW'(count_reg[win_sel_reg]);
                    state_next = ST_MEAN_W;
                end
            end
            ST_MEAN_W: begin
                if (unit_done) begin
                    mean_next[win_sel_reg] = sat_stat(unit_res);
                    state_next = ST_NSQ;
                end
            end
            ST_NSQ: begin
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                unit_a     = DW'(sq_reg[win_sel_reg]);
                unit_b     = DW'(count_reg[win_sel_reg]);
                state_next = ST_NSQ_W;
            end
            ST_NSQ_W: begin
                if (unit_done) begin
                    nsq_next   = unit_res;
                    state_next = ST_S2;
                end
            end
            ST_S2: begin
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                unit_a     = DW'(sum_reg[win_sel_reg]);
                unit_b     = DW'(sum_reg[win_sel_reg]);
                state_next = ST_S2_W;
            end
            ST_S2_W: begin
                if (unit_done) begin
                    s2_next    = unit_res;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                // A variance that is zero or below from rounding gives no spread.
                if (var_diff[DW] || (var_diff[DW-1:0] == '0)) begin
                    spread_next[win_sel_reg] = '0;
                    win_sel_next = 1'b1;
                    state_next   = win_sel_reg ? ST_DONE : ST_READ;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT;
                    unit_a     = var_diff[DW-1:0] << 8;
                    state_next = ST_ROOT_W;
                end
            end
            ST_ROOT_W: begin
                if (unit_done) begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    unit_a     = unit_res;
                    unit_b     = DW'(count_reg[win_sel_reg]);
                    state_next = ST_SDIV_W;
                end
            end
            ST_SDIV_W: begin
                if (unit_done) begin
                    spread_next[win_sel_reg] = sat_stat(unit_res);
                    win_sel_next = 1'b1;
                    state_next   = win_sel_reg ? ST_DONE : ST_READ;
                end
            end
            ST_DONE: begin
                // Wait until the output register is free, then hand the item over.
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            msg_reg       <= '0;
            for (int i = 0; i < 2; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                sum_reg[i]   <= '0;
                sq_reg[i]    <= '0;
            end
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            msg_reg       <= msg_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
        end
        win_sel_reg  <= win_sel_next;
        lat_val_reg  <= lat_val_next;
        gap_val_reg  <= gap_val_next;
        push_gap_reg <= push_gap_next;
        mean_reg     <= mean_next;
        spread_reg   <= spread_next;
        oldsq_reg    <= oldsq_next;
        nsq_reg      <= nsq_next;
        s2_reg       <= s2_next;
        if (load_out) begin
            o_lat_now_reg <= sat_now(lat_val_reg);
            o_gap_now_reg <= sat_now(gap_val_reg);
            o_lmean_reg   <= mean_reg[0];
            o_lspread_reg <= spread_reg[0];
            o_gmean_reg   <= mean_reg[1];
            o_gspread_reg <= spread_reg[1];
            o_lfill_reg   <= sat_fill(count_reg[0]);
            o_gfill_reg   <= sat_fill(count_reg[1]);
            o_total_reg   <= msg_reg;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_latency_now    = o_lat_now_reg;
    assign m_gap_now        = o_gap_now_reg;
    assign m_latency_mean   = o_lmean_reg;
    assign m_latency_spread = o_lspread_reg;
    assign m_gap_mean       = o_gmean_reg;
    assign m_gap_spread     = o_gspread_reg;
    assign m_latency_fill   = o_lfill_reg;
    assign m_gap_fill       = o_gfill_reg;
    assign m_message_total  = o_total_reg;

endmodule

>>> rtl/core/swljs_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module swljs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/swljs_serial_unit.sv
// Shared serial arithmetic unit: shift-add multiply, restoring divide and square root.
// Depends on swljs_pkg for the command type. One adder serves all three operations.
module swljs_serial_unit
    import swljs_pkg::*;
#(
    parameter int DW = 68
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  swljs_cmd_t    cmd,
    input  logic [DW-1:0] opa,
    input  logic [DW-1:0] opb,
    output logic [DW-1:0] result,
    output logic          done
);

    localparam int CW = $clog2(DW + 1);

    swljs_op_t     op_reg, op_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [DW-1:0] q_reg, q_next;
    logic [DW-1:0] x_reg, x_next;
    logic [DW-1:0] y_reg, y_next;

    logic [DW-1:0] add_a;
    logic [DW-1:0] add_b;
    logic          add_sub;
    logic [DW:0]   add_sum;

    always_comb begin
        unique case (op_reg)
            OP_DIV: begin
                add_a   = {acc_reg[DW-2:0], x_reg[DW-1]};
                add_b   = y_reg;
                add_sub = 1'b1;
            end
            OP_SQRT: begin
                add_a   = {acc_reg[DW-3:0], x_reg[DW-1:DW-2]};
                add_b   = {q_reg[DW-3:0], 2'b01};
                add_sub = 1'b1;
            end
            default: begin
                add_a   = acc_reg;
                add_b   = x_reg;
                add_sub = 1'b0;
            end
        endcase
        // With subtraction the top bit is set when no borrow occurred.
        add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (DW+1)'(add_sub);
    end

    always_comb begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (cmd.start) begin
            op_next   = cmd.op;
            busy_next = 1'b1;
            acc_next  = '0;
            q_next    = '0;
            x_next    = opa;
            y_next    = opb;
            cnt_next  = (cmd.op == OP_SQRT) ? CW'(DW / 2) : CW'(DW);
        end else if (busy_reg) begin
            if (op_reg == OP_MUL) begin
                if (y_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    if (y_reg[0]) begin
                        acc_next = add_sum[DW-1:0];
                    end
                    x_next = x_reg << 1;
                    y_next = y_reg >> 1;
                end
            end else begin
                if (add_sum[DW]) begin
                    acc_next = add_sum[DW-1:0];
                    q_next   = {q_reg[DW-2:0], 1'b1};
                end else begin
                    acc_next = add_a;
                    q_next   = {q_reg[DW-2:0], 1'b0};
                end
                x_next   = (op_reg == OP_SQRT) ? (x_reg << 2) : (x_reg << 1);
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign result = (op_reg == OP_MUL) ? acc_reg : q_reg;
    assign done   = done_reg;

endmodule

>>> rtl/core/swljs_checker.sv
// Port level checker of the latency and jitter statistics block, bound to the top level.
// Depends on swljs_pkg and the assertion macro header.
`include "sliding_window_latency_jitter_stats_top_defines.svh"

module swljs_checker
    import swljs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FILL_W-1:0]  m_latency_fill,
    input logic [FILL_W-1:0]  m_gap_fill
);

    // An accepted item makes the block busy, so it is not ready in the next cycle.
    `SWLJS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")

    // A result stays offered until it is taken.
    `SWLJS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid, "result dropped")

    // Every result follows at least one latency entry.
    `SWLJS_ASSERT_SAME(a_latency_filled, m_valid, m_latency_fill != '0, "empty latency window")

    // The gap window never holds more entries than the latency window.
    `SWLJS_ASSERT_SAME(a_gap_fill_order, m_valid, m_gap_fill <= m_latency_fill, "gap fill too big")

endmodule

bind sliding_window_latency_jitter_stats_top swljs_checker u_swljs_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the sliding window latency and jitter statistics block.
// Depends on swljs_pkg and sliding_window_latency_jitter_stats_top; holds its own
// predictor of the windows, means and deviations, and checks every result against it or a typed one.
module tb_top
    import swljs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = 32;
    localparam int VBITS        = 24;
    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int DRAIN_CYCLES = 800;
    localparam int HOLD_CYCLES  = 3000;
    localparam int HOLD_AFTER   = 300;
    localparam logic [63:0] VALUE_CAP = (64'd1 << VBITS) - 64'd1;
    localparam logic [63:0] STAT_CAP  = (64'd1 << STAT_W) - 64'd1;

    // One result item, field by field, at the widths of the ports.
    typedef struct packed {
        logic [NOW_W-1:0]   latency_now;
        logic [NOW_W-1:0]   gap_now;
        logic [STAT_W-1:0]  latency_mean;
        logic [STAT_W-1:0]  latency_spread;
        logic [STAT_W-1:0]  gap_mean;
        logic [STAT_W-1:0]  gap_spread;
        logic [FILL_W-1:0]  latency_fill;
        logic [FILL_W-1:0]  gap_fill;
        logic [TOTAL_W-1:0] message_total;
    } stats_t;

    // One row of the directed table. Rows with known_result set carry a result
    // that is typed in by hand; the others are checked against the predictor.
    typedef struct {
        logic [63:0] sent;
        logic [63:0] arrival;
        bit          known_result;
        stats_t      result;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [STAMP_W-1:0] s_sent_stamp;
    logic [STAMP_W-1:0] s_arrival_stamp;
    logic m_valid;
    logic m_ready;
    stats_t m_stats;

    sliding_window_latency_jitter_stats_top #(
        .WINDOW     (WIN),
        .VALUE_BITS (VBITS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sent_stamp     (s_sent_stamp),
        .s_arrival_stamp  (s_arrival_stamp),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_latency_now    (m_stats.latency_now),
        .m_gap_now        (m_stats.gap_now),
        .m_latency_mean   (m_stats.latency_mean),
        .m_latency_spread (m_stats.latency_spread),
        .m_gap_mean       (m_stats.gap_mean),
        .m_gap_spread     (m_stats.gap_spread),
        .m_latency_fill   (m_stats.latency_fill),
        .m_gap_fill       (m_stats.gap_fill),
        .m_message_total  (m_stats.message_total)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Predictor state: a copy of both rings with their heads, fills and exact sums.
    logic [23:0]  lat_ring [WIN];
    logic [23:0]  gap_ring [WIN];
    int unsigned  lat_head, gap_head, lat_count, gap_count;
    logic [63:0]  lat_sum, lat_sum_sq, gap_sum, gap_sum_sq;
    logic [63:0]  last_arrival;
    bit           seen_first;
    logic [31:0]  messages_seen;

    stats_t       pending_stats [$];
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;
    longint unsigned cycle_count = 0;

    // Integer square root, one result bit per step from the top down.
    function automatic logic [63:0] int_sqrt(input logic [127:0] x);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[63:0];
    endfunction

    // Mean and population deviation with 4 fractional bits. The deviation is
    // sqrt(256 * (n*sumsq - sum^2)) / n, which keeps everything in integers.
    function automatic void window_moments(input logic [63:0] sum, input logic [63:0] sum_sq,
                                           input int unsigned n,
                                           output logic [STAT_W-1:0] mean,
                                           output logic [STAT_W-1:0] spread);
        logic [127:0] n_sum_sq;
        logic [127:0] sum_squared;
        logic [63:0]  raw;
        mean = '0;
        spread = '0;
        if (n == 0)
            return;
        raw = (sum << 4) / n;
        mean = (raw > STAT_CAP) ? STAT_CAP[STAT_W-1:0] : raw[STAT_W-1:0];
        n_sum_sq = 128'(sum_sq) * n;
        sum_squared = 128'(sum) * 128'(sum);
        if (n_sum_sq <= sum_squared)
            return;
        raw = int_sqrt((n_sum_sq - sum_squared) << 8) / n;
        spread = (raw > STAT_CAP) ? STAT_CAP[STAT_W-1:0] : raw[STAT_W-1:0];
    endfunction

    // Difference of two stamps, 0 when time runs backwards, capped at the value width.
    function automatic logic [63:0] stamp_delta(input logic [63:0] later,
                                                input logic [63:0] earlier);
        logic [63:0] d;
        d = (later >= earlier) ? later - earlier : 64'd0;
        return (d > VALUE_CAP) ? VALUE_CAP : d;
    endfunction

    // Advances the predictor by one accepted message and returns its statistics.
    function automatic stats_t predict_stats(input logic [63:0] sent, input logic [63:0] arrival);
        stats_t r;
        logic [63:0] lat;
        logic [63:0] gap;
        logic [63:0] old;
        lat = stamp_delta(arrival, sent);
        gap = '0;
        messages_seen = messages_seen + 32'd1;

        if (lat_count >= WIN) begin
            old = lat_ring[lat_head];
            lat_sum = lat_sum - old;
            lat_sum_sq = lat_sum_sq - old * old;
        end else begin
            lat_count++;
        end
        lat_ring[lat_head] = lat[23:0];
        lat_sum = lat_sum + lat;
        lat_sum_sq = lat_sum_sq + lat * lat;
        lat_head = (lat_head + 1) % WIN;

        // The gap window only starts with the second message after reset.
        if (seen_first) begin
            gap = stamp_delta(arrival, last_arrival);
            if (gap_count >= WIN) begin
                old = gap_ring[gap_head];
                gap_sum = gap_sum - old;
                gap_sum_sq = gap_sum_sq - old * old;
            end else begin
                gap_count++;
            end
            gap_ring[gap_head] = gap[23:0];
            gap_sum = gap_sum + gap;
            gap_sum_sq = gap_sum_sq + gap * gap;
            gap_head = (gap_head + 1) % WIN;
        end
        last_arrival = arrival;
        seen_first = 1'b1;

        r.latency_now = lat[NOW_W-1:0];
        r.gap_now = gap[NOW_W-1:0];
        window_moments(lat_sum, lat_sum_sq, lat_count, r.latency_mean, r.latency_spread);
        window_moments(gap_sum, gap_sum_sq, gap_count, r.gap_mean, r.gap_spread);
        r.latency_fill = FILL_W'(lat_count);
        r.gap_fill = FILL_W'(gap_count);
        r.message_total = messages_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Result side. Samples at the rising edge, where every signal still holds
    // the value that it had before the edge, so the order of processes is moot.
    always @(posedge aclk) begin
        stats_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_stats.size() == 0) begin
                report_mismatch("result item with no message waiting", m_stats.message_total,
                                64'd0);
            end else begin
                want = pending_stats.pop_front();
                if (m_stats.latency_now !== want.latency_now)
                    report_mismatch("latency_now", m_stats.latency_now, want.latency_now);
                if (m_stats.gap_now !== want.gap_now)
                    report_mismatch("gap_now", m_stats.gap_now, want.gap_now);
                if (m_stats.latency_mean !== want.latency_mean)
                    report_mismatch("latency_mean", m_stats.latency_mean, want.latency_mean);
                if (m_stats.latency_spread !== want.latency_spread)
                    report_mismatch("latency_spread", m_stats.latency_spread,
                                    want.latency_spread);
                if (m_stats.gap_mean !== want.gap_mean)
                    report_mismatch("gap_mean", m_stats.gap_mean, want.gap_mean);
                if (m_stats.gap_spread !== want.gap_spread)
                    report_mismatch("gap_spread", m_stats.gap_spread, want.gap_spread);
                if (m_stats.latency_fill !== want.latency_fill)
                    report_mismatch("latency_fill", m_stats.latency_fill, want.latency_fill);
                if (m_stats.gap_fill !== want.gap_fill)
                    report_mismatch("gap_fill", m_stats.gap_fill, want.gap_fill);
                if (m_stats.message_total !== want.message_total)
                    report_mismatch("message_total", m_stats.message_total,
                                    want.message_total);
            end
        end
    end

    // Receiver stalls. The pattern switches at random moments between
    // always ready, a coin toss and rarely ready. Once, after a few hundred
    // results, it holds off for a long stretch so that the block fills up
    // and has to stall its input while the sender keeps offering items.
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(50, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Run limit, counted in its own process.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one message and holds it until the block takes it; the predictor
    // advances at the edge of acceptance. valid stays high on return, so a
    // following item in the same burst goes out without a dead cycle.
    task automatic offer_message(input logic [63:0] sent, input logic [63:0] arrival,
                                 input bit known_result, input stats_t typed);
        stats_t predicted;
        s_valid <= 1'b1;
        s_sent_stamp <= sent;
        s_arrival_stamp <= arrival;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = predict_stats(sent, arrival);
        pending_stats.push_back(known_result ? typed : predicted);
    endtask

    // Random widths give small and large values alike, up to past saturation.
    function automatic logic [63:0] random_span();
        logic [63:0] v;
        int unsigned bits;
        v = {$urandom, $urandom};
        bits = $urandom_range(0, 26);
        return (bits == 0) ? 64'd0 : v & ((64'd1 << bits) - 64'd1);
    endfunction

    stim_row_t   directed_rows [$];
    logic [63:0] clock_base;
    logic [63:0] sent_v;
    logic [63:0] arrival_v;
    int unsigned burst_left;
    int unsigned items_sent;
    int unsigned kind;

    task automatic add_row(input logic [63:0] sent, input logic [63:0] arrival);
        stim_row_t row;
        row.sent = sent;
        row.arrival = arrival;
        row.known_result = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endtask

    initial begin
        stim_row_t row;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sent_stamp = '0;
        s_arrival_stamp = '0;
        lat_head = 0;
        gap_head = 0;
        lat_count = 0;
        gap_count = 0;
        lat_sum = '0;
        lat_sum_sq = '0;
        gap_sum = '0;
        gap_sum_sq = '0;
        last_arrival = '0;
        seen_first = 1'b0;
        messages_seen = '0;

        // First message after reset: both windows start from nothing, the gap
        // window stays empty, so every mean, spread and current value reads 0.
        row.sent = 64'd0;
        row.arrival = 64'd0;
        row.known_result = 1'b1;
        row.result = '0;
        row.result.latency_fill = 6'd1;
        row.result.message_total = 32'd1;
        directed_rows.push_back(row);
        // Arrival before sending counts as zero latency; the first gap is 50,
        // so the gap mean is 50 with 4 fractional bits and the spread is 0.
        row.sent = 64'd100;
        row.arrival = 64'd50;
        row.result = '0;
        row.result.gap_now = 24'd50;
        row.result.gap_mean = 28'd800;
        row.result.latency_fill = 6'd2;
        row.result.gap_fill = 6'd1;
        row.result.message_total = 32'd2;
        directed_rows.push_back(row);

        add_row(64'd0, '1);                       // both values far past saturation
        add_row('1, '1);                          // extreme stamps, zero latency and gap
        add_row('1, 64'd0);                       // both differences run backwards
        add_row(64'h8000_0000_0000_0000, 64'h8000_0000_00FF_FFFF); // exactly at the cap
        add_row(64'h8000_0000_0000_0000, 64'h8000_0000_0100_0000); // one past the cap
        add_row(64'h8000_0000_00FF_FFFF, 64'h8000_0000_0100_0000); // arrival stamp one above the sent stamp
        add_row(64'h8000_0000_0100_0000, 64'h8000_0000_0100_0000); // repeated arrival
        add_row(64'h0000_0000_1234_5678, 64'h0000_0000_1234_5679); // arrival goes back
        add_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        add_row(64'd7, 64'd1000);
        add_row(64'd900, 64'd2000);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_message(directed_rows[i].sent, directed_rows[i].arrival,
                          directed_rows[i].known_result, directed_rows[i].result);

        // Random part. Most items come from a steady clock with random arrival
        // gaps and latencies, so the windows fill, wrap and evict real data;
        // the rest are unrelated stamps and arrivals that jump backwards.
        clock_base = {$urandom, $urandom};
        burst_left = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                sent_v = {$urandom, $urandom};
                arrival_v = {$urandom, $urandom};
            end else if (kind == 1) begin
                arrival_v = clock_base - random_span();
                sent_v = arrival_v - random_span();
            end else begin
                if ($urandom_range(0, 49) == 0)
                    clock_base = {$urandom, $urandom};
                clock_base = clock_base + random_span();
                arrival_v = clock_base;
                sent_v = arrival_v - random_span();
            end
            offer_message(sent_v, arrival_v, 1'b0, '0);
            items_sent++;

            // Sender bursts: valid stays high inside a burst and drops for a
            // random gap between most bursts.
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge aclk);
                end
            end else begin
                burst_left--;
            end
        end
        s_valid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
